/* hdl/ccrgba_pkg.sv */
// ----------------------------------------------------------------------------
// ccrgba_pkg
// Shared types, constants and helpers for the css color to rgba8 pipeline.
// ----------------------------------------------------------------------------
package ccrgba_pkg;

    // stage 1 up to the stage that feeds the output register
    localparam int PIPE_DEPTH = 9;
    // taps after the rgb scaler (stage 3) up to stage 9
    localparam int RGB_DLY    = 7;

    localparam logic [14:0] PCT_FULL  = 15'd25600;
    localparam logic [13:0] PCT_HALF  = 14'd12800;
    localparam logic [16:0] HUE_TURN  = 17'd92160;
    // multiple of 45 that lifts hue / 2048 above zero
    localparam logic [21:0] HUE_OFS   = 22'd1048590;
    // ceil(2^27 / 45)
    localparam logic [21:0] HUE_RECIP = 22'd2982617;
    // ceil(2^19 / 100)
    localparam logic [12:0] PCT_RECIP = 13'd5243;
    // 25600 * 25600 * 7680 = 2^29 * 9375
    localparam logic [42:0] HSL_DEN   = 43'd5033164800000;
    localparam logic [41:0] HSL_HALF  = 42'd2516582400000;
    // ceil(2^36 / 9375)
    localparam logic [22:0] DEN_RECIP = 23'd7330078;

    typedef enum logic [1:0] {
        SCALE_NUM,
        SCALE_PCT,
        SCALE_UNIT
    } t_scale;

    typedef enum logic [1:0] {
        CH_RED,
        CH_GREEN,
        CH_BLUE
    } t_chan;

    typedef struct packed {
        logic vld;
        logic cmd;
        logic alpha_given;
    } t_ctl;

    // twelfth-turn offset of each channel in 1/256 degree
    function automatic logic [15:0] chan_offset(input t_chan c);
        logic [15:0] v;
        case (c)
            CH_RED:   v = 16'd0;
            CH_GREEN: v = 16'd61440;
            CH_BLUE:  v = 16'd30720;
            default:  v = 16'd0;
        endcase
        return v;
    endfunction

    // clamp a Q23.8 value to 0..100 percent
    function automatic logic [14:0] clamp_pct(input logic signed [31:0] x);
        logic [14:0] v;
        if (x[31]) begin
            v = 15'd0;
        end else if (x > $signed({17'd0, PCT_FULL})) begin
            v = PCT_FULL;
        end else begin
            v = x[14:0];
        end
        return v;
    endfunction

endpackage

/* hdl/ccrgba_hue_red.sv */
// ----------------------------------------------------------------------------
// ccrgba_hue_red
// Reduces the hue mod 360 degrees and clamps saturation and lightness,
// stages 1 to 3.
// ----------------------------------------------------------------------------
module ccrgba_hue_red
    import ccrgba_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [31:0] i_first_component,
    input  logic signed [31:0] i_second_component,
    input  logic signed [31:0] i_third_component,
    output logic        [16:0] o_hue,
    output logic        [14:0] o_sat,
    output logic        [14:0] o_lit
);

    logic [21:0] n_u;
    logic [21:0] r_u1;
    logic [10:0] r_low1;
    logic [14:0] r_sat1;
    logic [14:0] r_lit1;

    logic [43:0] n_prod;
    logic [16:0] r_q2;
    logic [21:0] r_u2;
    logic [10:0] r_low2;
    logic [14:0] r_sat2;
    logic [14:0] r_lit2;

    logic [21:0] n_rem;
    logic [16:0] r_hue3;
    logic [14:0] r_sat3;
    logic [14:0] r_lit3;

    // floor(hue / 2048) lifted positive, low 11 bits ride along
    assign n_u    = 22'(23'($signed(i_first_component[31:11])) + 23'(HUE_OFS));
    assign n_prod = 44'(r_u1) * 44'(HUE_RECIP);
    assign n_rem  = r_u2 - 22'(22'(r_q2) * 22'd45);

    always_ff @(posedge i_clk) begin
        r_u1   <= n_u;
        r_low1 <= i_first_component[10:0];
        r_sat1 <= clamp_pct(i_second_component);
        r_lit1 <= clamp_pct(i_third_component);

        r_q2   <= n_prod[43:27];
        r_u2   <= r_u1;
        r_low2 <= r_low1;
        r_sat2 <= r_sat1;
        r_lit2 <= r_lit1;

        r_hue3 <= {n_rem[5:0], r_low2};
        r_sat3 <= r_sat2;
        r_lit3 <= r_lit2;
    end

    assign o_hue = r_hue3;
    assign o_sat = r_sat3;
    assign o_lit = r_lit3;

endmodule

/* hdl/ccrgba_hsl_chan.sv */
// ----------------------------------------------------------------------------
// ccrgba_hsl_chan
// One hsl channel: twelfth-turn ramp, lightness mix and rounding to a byte,
// stages 4 to 9.
// ----------------------------------------------------------------------------
module ccrgba_hsl_chan
    import ccrgba_pkg::*;
(
    input  logic        i_clk,
    input  t_chan       i_chan,
    input  logic [16:0] i_hue,
    input  logic [14:0] i_sat,
    input  logic [14:0] i_lit,
    output logic [7:0]  o_byte
);

    logic        [17:0] n_ksum;
    logic        [16:0] n_k;
    logic signed [18:0] n_m0;
    logic signed [18:0] n_t0;
    logic signed [18:0] n_mm;
    logic signed [13:0] n_m;
    logic        [13:0] n_mn;

    logic signed [13:0] r_m4;
    logic        [13:0] r_mn4;
    logic        [14:0] r_sat4;
    logic        [14:0] r_lit4;

    logic        [28:0] r_a5;
    logic        [23:0] r_lk5;
    logic signed [13:0] r_m5;

    logic signed [43:0] r_am6;
    logic        [23:0] r_lk6;

    logic signed [43:0] n_num;
    logic        [42:0] r_num7;

    logic        [50:0] n_v;
    logic        [21:0] r_w8;

    logic        [44:0] n_p;
    logic        [7:0]  r_byte9;

    always_comb begin
        n_ksum = 18'(i_hue) + 18'(chan_offset(i_chan));
        n_k    = (n_ksum >= 18'(HUE_TURN)) ? 17'(n_ksum - 18'(HUE_TURN)) : 17'(n_ksum);
        n_m0   = $signed({2'b00, n_k}) - 19'sd23040;
        n_t0   = 19'sd69120 - $signed({2'b00, n_k});
        n_mm   = (n_t0 < n_m0) ? n_t0 : n_m0;
        if (n_mm > 19'sd7680) begin
            n_m = 14'sd7680;
        end else if (n_mm < -19'sd7680) begin
            n_m = -14'sd7680;
        end else begin
            n_m = 14'(n_mm);
        end
        n_mn = (i_lit <= 15'(PCT_HALF)) ? 14'(i_lit) : 14'(PCT_FULL - i_lit);
    end

    // l * 25600 * 7680 is lk << 19
    assign n_num = $signed({1'b0, r_lk6, 19'd0}) - r_am6;
    assign n_v   = {r_num7, 8'd0} - 51'(r_num7) + 51'(HSL_HALF);
    assign n_p   = 45'(r_w8) * 45'(DEN_RECIP);

    always_ff @(posedge i_clk) begin
        r_m4   <= n_m;
        r_mn4  <= n_mn;
        r_sat4 <= i_sat;
        r_lit4 <= i_lit;

        r_a5   <= 29'(r_sat4) * 29'(r_mn4);
        r_lk5  <= 24'(r_lit4) * 24'd375;
        r_m5   <= r_m4;

        r_am6  <= $signed({15'd0, r_a5}) * 44'(r_m5);
        r_lk6  <= r_lk5;

        if (n_num[43]) begin
            r_num7 <= 43'd0;
        end else if (n_num[42:0] > HSL_DEN) begin
            r_num7 <= HSL_DEN;
        end else begin
            r_num7 <= n_num[42:0];
        end

        r_w8    <= n_v[50:29];
        r_byte9 <= n_p[43:36];
    end

    assign o_byte = r_byte9;

endmodule

/* hdl/ccrgba_rgb_chan.sv */
// ----------------------------------------------------------------------------
// ccrgba_rgb_chan
// Scales one number, percentage or unit fraction to a byte, then delays it
// to line up with the hsl channels.
// ----------------------------------------------------------------------------
module ccrgba_rgb_chan
    import ccrgba_pkg::*;
(
    input  logic               i_clk,
    input  logic signed [31:0] i_comp,
    input  t_scale             i_mode,
    output logic        [7:0]  o_byte
);

    logic [15:0] n_cn;
    logic [8:0]  n_cu;
    logic [16:0] n_nb;
    logic [16:0] n_ub;
    logic [7:0]  n_simple;

    logic [7:0]  r_simple1;
    logic [14:0] r_c1;
    t_scale      r_mode1;

    logic [22:0] n_v;
    logic [14:0] r_w2;
    logic [7:0]  r_simple2;
    t_scale      r_mode2;

    logic [26:0] n_q;
    logic [7:0]  r_dly [RGB_DLY];

    always_comb begin
        if (i_comp[31]) begin
            n_cn = 16'd0;
            n_cu = 9'd0;
        end else begin
            n_cn = (i_comp > 32'sd65280) ? 16'd65280 : i_comp[15:0];
            n_cu = (i_comp > 32'sd256) ? 9'd256 : i_comp[8:0];
        end
        n_nb     = 17'(n_cn) + 17'd128;
        n_ub     = {n_cu, 8'd0} - 17'(n_cu) + 17'd128;
        n_simple = (i_mode == SCALE_UNIT) ? n_ub[15:8] : n_nb[15:8];
    end

    assign n_v = {r_c1, 8'd0} - 23'(r_c1) + 23'(PCT_HALF);
    // divide by 100 through the reciprocal
    assign n_q = 27'(r_w2) * 27'(PCT_RECIP);

    always_ff @(posedge i_clk) begin
        r_simple1 <= n_simple;
        r_c1      <= clamp_pct(i_comp);
        r_mode1   <= i_mode;

        r_w2      <= n_v[22:8];
        r_simple2 <= r_simple1;
        r_mode2   <= r_mode1;

        r_dly[0]  <= (r_mode2 == SCALE_PCT) ? n_q[26:19] : r_simple2;
        for (int i = 1; i < RGB_DLY; i++) begin
            r_dly[i] <= r_dly[i-1];
        end
    end

    assign o_byte = r_dly[RGB_DLY-1];

endmodule

/* hdl/css_color_components_to_rgba8.sv */
// timing: o_valid is registered; an accepted start runs down the r_ctl valid pipe, then r_valid drives o_valid
// throughput: one beat per cycle; every stage of the nine-stage pipe takes a new beat each cycle
// busy is tied low; every cycle can take a beat and results are never stalled
// reset: synchronous active-low i_rst_n clears the valid pipe and o_valid;
// data registers are not reset
// ----------------------------------------------------------------------------
// css_color_components_to_rgba8
// Converts one parsed css rgb or hsl color with optional alpha into rgba bytes.
// ----------------------------------------------------------------------------
module css_color_components_to_rgba8
    import ccrgba_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic               i_cmd,
    input  logic signed [31:0] i_first_component,
    input  logic signed [31:0] i_second_component,
    input  logic signed [31:0] i_third_component,
    input  logic signed [31:0] i_alpha_component,
    input  logic               i_first_is_pct,
    input  logic               i_second_is_pct,
    input  logic               i_third_is_pct,
    input  logic               i_alpha_is_pct,
    input  logic               i_alpha_given,
    output logic               o_valid,
    output logic        [7:0]  o_red_byte,
    output logic        [7:0]  o_green_byte,
    output logic        [7:0]  o_blue_byte,
    output logic        [7:0]  o_alpha_byte
);

    t_ctl        n_ctl;
    t_ctl        r_ctl [PIPE_DEPTH];

    logic [16:0] w_hue;
    logic [14:0] w_sat;
    logic [14:0] w_lit;
    logic [7:0]  w_hsl_r;
    logic [7:0]  w_hsl_g;
    logic [7:0]  w_hsl_b;
    logic [7:0]  w_rgb_r;
    logic [7:0]  w_rgb_g;
    logic [7:0]  w_rgb_b;
    logic [7:0]  w_alpha;

    logic        r_valid;
    logic [7:0]  r_red;
    logic [7:0]  r_green;
    logic [7:0]  r_blue;
    logic [7:0]  r_alpha;

    assign busy  = 1'b0;
    assign n_ctl = '{vld: start && !busy, cmd: i_cmd, alpha_given: i_alpha_given};

    ccrgba_hue_red u_hue (
        .i_clk              (i_clk),
        .i_first_component  (i_first_component),
        .i_second_component (i_second_component),
        .i_third_component  (i_third_component),
        .o_hue              (w_hue),
        .o_sat              (w_sat),
        .o_lit              (w_lit)
    );

    ccrgba_hsl_chan u_hsl_r (
        .i_clk  (i_clk),
        .i_chan (CH_RED),
        .i_hue  (w_hue),
        .i_sat  (w_sat),
        .i_lit  (w_lit),
        .o_byte (w_hsl_r)
    );

    ccrgba_hsl_chan u_hsl_g (
        .i_clk  (i_clk),
        .i_chan (CH_GREEN),
        .i_hue  (w_hue),
        .i_sat  (w_sat),
        .i_lit  (w_lit),
        .o_byte (w_hsl_g)
    );

    ccrgba_hsl_chan u_hsl_b (
        .i_clk  (i_clk),
        .i_chan (CH_BLUE),
        .i_hue  (w_hue),
        .i_sat  (w_sat),
        .i_lit  (w_lit),
        .o_byte (w_hsl_b)
    );

    ccrgba_rgb_chan u_rgb_r (
        .i_clk  (i_clk),
        .i_comp (i_first_component),
        .i_mode (i_first_is_pct ? SCALE_PCT : SCALE_NUM),
        .o_byte (w_rgb_r)
    );

    ccrgba_rgb_chan u_rgb_g (
        .i_clk  (i_clk),
        .i_comp (i_second_component),
        .i_mode (i_second_is_pct ? SCALE_PCT : SCALE_NUM),
        .o_byte (w_rgb_g)
    );

    ccrgba_rgb_chan u_rgb_b (
        .i_clk  (i_clk),
        .i_comp (i_third_component),
        .i_mode (i_third_is_pct ? SCALE_PCT : SCALE_NUM),
        .o_byte (w_rgb_b)
    );

    ccrgba_rgb_chan u_alpha (
        .i_clk  (i_clk),
        .i_comp (i_alpha_component),
        .i_mode (i_alpha_is_pct ? SCALE_PCT : SCALE_UNIT),
        .o_byte (w_alpha)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < PIPE_DEPTH; i++) begin
                r_ctl[i] <= '0;
            end
            r_valid <= 1'b0;
        end else begin
            r_ctl[0] <= n_ctl;
            for (int i = 1; i < PIPE_DEPTH; i++) begin
                r_ctl[i] <= r_ctl[i-1];
            end
            r_valid <= r_ctl[PIPE_DEPTH-1].vld;
        end
    end

    // output beat register, mode select at the last stage
    always_ff @(posedge i_clk) begin
        r_red   <= r_ctl[PIPE_DEPTH-1].cmd ? w_hsl_r : w_rgb_r;
        r_green <= r_ctl[PIPE_DEPTH-1].cmd ? w_hsl_g : w_rgb_g;
        r_blue  <= r_ctl[PIPE_DEPTH-1].cmd ? w_hsl_b : w_rgb_b;
        r_alpha <= r_ctl[PIPE_DEPTH-1].alpha_given ? w_alpha : 8'd255;
    end

    assign o_valid      = r_valid;
    assign o_red_byte   = r_red;
    assign o_green_byte = r_green;
    assign o_blue_byte  = r_blue;
    assign o_alpha_byte = r_alpha;

    a_valid_from_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> $past(start && !busy, 10))
        else $error("result beat without an accepted command");

    a_alpha_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !$past(i_alpha_given, 10) |-> o_alpha_byte == 8'd255)
        else $error("absent alpha not opaque");

    a_gray_hsl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(i_cmd && (i_second_component <= 32'sd0), 10)
        |-> (o_red_byte == o_green_byte) && (o_green_byte == o_blue_byte))
        else $error("zero saturation hsl gave a non-gray beat");

    a_red_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && $past(!i_cmd && !i_first_is_pct && (i_first_component >= 32'sd65280), 10)
        |-> o_red_byte == 8'd255)
        else $error("red number above range not clamped");

endmodule
